// File: hdl/wbrs_pkg.sv
// ----------------------------------------------------------------------------
// wbrs_pkg
// Shared types and constants of the white blob region steering unit.
// ----------------------------------------------------------------------------
package wbrs_pkg;

   localparam int FRAME_WIDTH_BITS = 12;
   localparam int ROW_STRIDE_BITS  = 4;
   localparam int LIMIT_BITS       = 12;
   localparam int CSR_INDEX_BITS   = 4;
   localparam int CSR_DATA_BITS    = 12;
   localparam int PIXEL_BITS       = 24;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_CNT_BITS   = 3;

   localparam logic [7:0] WHITE_LEVEL = 8'd255;

   localparam logic [FRAME_WIDTH_BITS-1:0] FRAME_WIDTH_RESET = 12'd640;
   localparam logic [ROW_STRIDE_BITS-1:0]  ROW_STRIDE_RESET  = 4'd3;
   localparam logic [LIMIT_BITS-1:0]       LEFT_LIMIT_RESET  = 12'd213;
   localparam logic [LIMIT_BITS-1:0]       RIGHT_LIMIT_RESET = 12'd426;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH = 4'd0,
      CSR_ROW_STRIDE  = 4'd1,
      CSR_LEFT_LIMIT  = 4'd2,
      CSR_RIGHT_LIMIT = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_NONE   = 2'd0,
      REGION_LEFT   = 2'd1,
      REGION_MIDDLE = 2'd2,
      REGION_RIGHT  = 2'd3
   } region_type;

   typedef enum logic [1:0] {
      DEC_STOP    = 2'd0,
      DEC_LEFT    = 2'd1,
      DEC_RIGHT   = 2'd2,
      DEC_FORWARD = 2'd3
   } decision_type;

   typedef struct packed {
      logic [FRAME_WIDTH_BITS-1:0] frame_width;
      logic [ROW_STRIDE_BITS-1:0]  row_stride;
      logic [LIMIT_BITS-1:0]       left_limit;
      logic [LIMIT_BITS-1:0]       right_limit;
   } cfg_type;

   typedef struct packed {
      region_type region;
      logic       last;
   } q_word_type;

endpackage

// File: hdl/wbrs_front.sv
// ----------------------------------------------------------------------------
// wbrs_front
// Tracks raster position, detects white pixels and tags those on sampled rows with their region.
// ----------------------------------------------------------------------------
module wbrs_front
   import wbrs_pkg::*;
#(
   parameter int COLUMN_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pix_valid,
   output logic       pix_ready,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   input  logic       last,
   input  logic       q_full,
   output logic       q_push,
   output q_word_type q_word
);

   localparam int CMP_BITS = ((COLUMN_BITS > LIMIT_BITS) ? COLUMN_BITS : LIMIT_BITS) + 1;

   logic [COLUMN_BITS-1:0]     column_ff, column_in;
   logic [ROW_STRIDE_BITS-1:0] phase_ff, phase_in;
   logic [COLUMN_BITS:0]       col_plus;
   logic [ROW_STRIDE_BITS-1:0] phase_plus;
   logic [CMP_BITS-1:0]        col_ext, col_plus_ext, width_ext, left_ext, right_ext;
   logic                       white;
   logic                       wrap;

   assign pix_ready = !q_full;
   assign q_push    = pix_valid && pix_ready;

   assign white = (red == WHITE_LEVEL) && (green == WHITE_LEVEL) && (blue == WHITE_LEVEL);

   assign col_plus     = {1'b0, column_ff} + {{COLUMN_BITS{1'b0}}, 1'b1};
   assign col_ext      = CMP_BITS'(column_ff);
   assign col_plus_ext = CMP_BITS'(col_plus);
   assign width_ext    = CMP_BITS'(cfg.frame_width);
   assign left_ext     = CMP_BITS'(cfg.left_limit);
   assign right_ext    = CMP_BITS'(cfg.right_limit);
   assign wrap         = (col_plus_ext >= width_ext) || col_plus[COLUMN_BITS];
   assign phase_plus   = phase_ff + 4'd1;

   always_comb begin
      q_word.last = last;
      if (!white || (phase_ff != '0)) begin
         q_word.region = REGION_NONE;
      end else if (col_ext <= left_ext) begin
         q_word.region = REGION_LEFT;
      end else if (col_ext >= right_ext) begin
         q_word.region = REGION_RIGHT;
      end else begin
         q_word.region = REGION_MIDDLE;
      end

      column_in = column_ff;
      phase_in  = phase_ff;
      if (q_push) begin
         if (last) begin
            column_in = '0;
            phase_in  = '0;
         end else if (wrap) begin
            column_in = '0;
            phase_in  = (phase_plus >= cfg.row_stride) ? '0 : phase_plus;
         end else begin
            column_in = col_plus[COLUMN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         phase_ff  <= '0;
      end else begin
         column_ff <= column_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

// File: hdl/wbrs_queue.sv
// ----------------------------------------------------------------------------
// wbrs_queue
// Short FIFO of tagged pixel words between the front and the back.
// ----------------------------------------------------------------------------
module wbrs_queue
   import wbrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_word_type push_word,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output q_word_type head
);

   q_word_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/wbrs_back.sv
// ----------------------------------------------------------------------------
// wbrs_back
// Saturating region tallies, frame snapshot and steering decision output.
// ----------------------------------------------------------------------------
module wbrs_back
   import wbrs_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  q_word_type            q_head,
   output logic                  q_pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output decision_type          decision,
   output logic [COUNT_BITS-1:0] left_count,
   output logic [COUNT_BITS-1:0] middle_count,
   output logic [COUNT_BITS-1:0] right_count
);

   logic [COUNT_BITS-1:0] left_ff, left_in, middle_ff, middle_in, right_ff, right_in;
   logic [COUNT_BITS-1:0] left_inc, middle_inc, right_inc;
   logic                  snap_valid_ff, snap_valid_in;
   logic [COUNT_BITS-1:0] snap_left_ff, snap_middle_ff, snap_right_ff;
   logic                  out_valid_ff, out_valid_in;
   decision_type          out_dec_ff, dec_in;
   logic [COUNT_BITS-1:0] out_left_ff, out_middle_ff, out_right_ff;
   logic                  out_load;
   logic                  snap_ready;
   logic                  snap_load;

   assign out_load   = snap_valid_ff && (!out_valid_ff || out_ready);
   assign snap_ready = !snap_valid_ff || out_load;
   assign q_pop      = !q_empty && (!q_head.last || snap_ready);
   assign snap_load  = q_pop && q_head.last;

   assign out_valid    = out_valid_ff;
   assign decision     = out_dec_ff;
   assign left_count   = out_left_ff;
   assign middle_count = out_middle_ff;
   assign right_count  = out_right_ff;

   always_comb begin
      left_inc   = left_ff;
      middle_inc = middle_ff;
      right_inc  = right_ff;
      case (q_head.region)
         REGION_LEFT:   left_inc   = (left_ff == '1)   ? left_ff   : left_ff + 1'b1;
         REGION_MIDDLE: middle_inc = (middle_ff == '1) ? middle_ff : middle_ff + 1'b1;
         REGION_RIGHT:  right_inc  = (right_ff == '1)  ? right_ff  : right_ff + 1'b1;
         default: ;
      endcase

      left_in   = left_ff;
      middle_in = middle_ff;
      right_in  = right_ff;
      if (q_pop) begin
         if (q_head.last) begin
            left_in   = '0;
            middle_in = '0;
            right_in  = '0;
         end else begin
            left_in   = left_inc;
            middle_in = middle_inc;
            right_in  = right_inc;
         end
      end

      if ((snap_left_ff == '0) && (snap_middle_ff == '0) && (snap_right_ff == '0)) begin
         dec_in = DEC_STOP;
      end else if ((snap_left_ff >= snap_middle_ff) && (snap_left_ff >= snap_right_ff)) begin
         dec_in = DEC_LEFT;
      end else if (snap_right_ff >= snap_middle_ff) begin
         dec_in = DEC_RIGHT;
      end else begin
         dec_in = DEC_FORWARD;
      end

      snap_valid_in = snap_load || (snap_valid_ff && !out_load);
      out_valid_in  = out_load  || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_left_ff   <= left_inc;
         snap_middle_ff <= middle_inc;
         snap_right_ff  <= right_inc;
      end
      if (out_load) begin
         out_dec_ff    <= dec_in;
         out_left_ff   <= snap_left_ff;
         out_middle_ff <= snap_middle_ff;
         out_right_ff  <= snap_right_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         middle_ff     <= '0;
         right_ff      <= '0;
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         left_ff       <= left_in;
         middle_ff     <= middle_in;
         right_ff      <= right_in;
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

// File: hdl/white_blob_region_steering_unit.sv
// ----------------------------------------------------------------------------
// white_blob_region_steering_unit
// Counts white pixels per column region and steers toward the largest count.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one RGB pixel word per cycle in raster order while the queue has
//   room; req_tlast marks the last pixel of a frame. Only that word produces a
//   response on rsp_*: the steering decision and the three saturating region
//   counts, after which the counts and the raster position clear.
//   csr_* writes one register per handshake: 0 frame_width, 1 row_stride,
//   2 left_limit, 3 right_limit; other indexes are dropped. Write only while
//   no frame word is in flight.
// Timing:
//   Throughput is one pixel per cycle while the queue has room. A frame-end word
//   reaches rsp_* through the queue, the snapshot register and the output register.
//   While rsp_tready is low the response holds; the front keeps taking pixels
//   until the four-entry queue fills, and the back keeps counting until a
//   second frame end finds the snapshot register occupied.
// Reset:
//   Synchronous, active high. Registers return to their defaults (640, 3, 213,
//   426), counts and position clear, and no response is pending.
// ----------------------------------------------------------------------------
module white_blob_region_steering_unit
   import wbrs_pkg::*;
#(
   parameter  int COUNT_BITS  = 20,
   parameter  int COLUMN_BITS = 12,
   localparam int RSP_BITS    = ((2 + 3 * COUNT_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [PIXEL_BITS-1:0]     req_tdata,   // red, green, blue
   input  logic                      req_tlast,   // frame_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_BITS-1:0]       rsp_tdata,   // decision, left_count, middle_count, right_count
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type               cfg_ff, cfg_in;
   logic                  q_full, q_empty, q_push, q_pop;
   q_word_type            q_word, q_head;
   decision_type          decision;
   logic [COUNT_BITS-1:0] left_count, middle_count, right_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH: cfg_in.frame_width = csr_data[FRAME_WIDTH_BITS-1:0];
            CSR_ROW_STRIDE:  cfg_in.row_stride  = csr_data[ROW_STRIDE_BITS-1:0];
            CSR_LEFT_LIMIT:  cfg_in.left_limit  = csr_data[LIMIT_BITS-1:0];
            CSR_RIGHT_LIMIT: cfg_in.right_limit = csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= FRAME_WIDTH_RESET;
         cfg_ff.row_stride  <= ROW_STRIDE_RESET;
         cfg_ff.left_limit  <= LEFT_LIMIT_RESET;
         cfg_ff.right_limit <= RIGHT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wbrs_front #(
      .COLUMN_BITS (COLUMN_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pix_valid (req_tvalid),
      .pix_ready (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .last      (req_tlast),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_word    (q_word)
   );

   wbrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   wbrs_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .decision     (decision),
      .left_count   (left_count),
      .middle_count (middle_count),
      .right_count  (right_count)
   );

   assign rsp_tdata = RSP_BITS'({right_count, middle_count, left_count, decision});

endmodule

// File: hdl/wbrs_checker.sv
// ----------------------------------------------------------------------------
// wbrs_checker
// Port-level checks on the steering responses, bound to the top level.
// ----------------------------------------------------------------------------
module wbrs_checker
   import wbrs_pkg::*;
#(
   parameter  int COUNT_BITS = 20,
   localparam int RSP_BITS   = ((2 + 3 * COUNT_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   logic [1:0]            dec;
   logic [COUNT_BITS-1:0] lc, mc, rc;

   assign dec = rsp_tdata[1:0];
   assign lc  = rsp_tdata[2 +: COUNT_BITS];
   assign mc  = rsp_tdata[2 + COUNT_BITS +: COUNT_BITS];
   assign rc  = rsp_tdata[2 + 2 * COUNT_BITS +: COUNT_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((dec == DEC_STOP) == ((lc == '0) && (mc == '0) && (rc == '0))))
      else $error("stop decision does not match empty counts");

   a_left: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (dec == DEC_LEFT) |-> (lc >= mc) && (lc >= rc) && (lc != '0))
      else $error("left decision without left maximum");

   a_right: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (dec == DEC_RIGHT) |-> (rc >= mc) && (rc > lc))
      else $error("right decision without right maximum");

endmodule

bind white_blob_region_steering_unit wbrs_checker #(.COUNT_BITS(COUNT_BITS)) u_wbrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the white blob region steering unit. Pixel words
// stream in raster order from a queue-fed driver. An in-bench tally of the
// white pixels per column region predicts each frame-end response. A
// monitor compares every response word field by field. Directed frames
// cover the region edges, ties, crossed limits, zero settings and a width
// lowered in mid-row. Random phases follow with varied settings, sender
// gaps and receiver stalls, and one long stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
   import wbrs_pkg::*;

   localparam int COUNT_BITS  = 20;
   localparam int RSP_BITS    = ((2 + 3 * COUNT_BITS + 7) / 8) * 8;
   localparam int IDLE_LIMIT  = 4000;
   localparam int LONG_HOLD   = 300;
   localparam int QUEUE_ROOM  = 64;
   localparam logic [COUNT_BITS-1:0]     COUNT_MAX        = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 4'd9;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } pixel_word_type;

   typedef struct {
      decision_type          decision;
      logic [COUNT_BITS-1:0] left_count;
      logic [COUNT_BITS-1:0] middle_count;
      logic [COUNT_BITS-1:0] right_count;
   } steer_word_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [PIXEL_BITS-1:0]     req_tdata  = '0;   // red, green, blue
   logic                      req_tlast  = 1'b0; // frame_end
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;         // decision, left_count, middle_count, right_count
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // settings and raster state as the block should hold them
   logic [FRAME_WIDTH_BITS-1:0] width_setting  = FRAME_WIDTH_RESET;
   logic [ROW_STRIDE_BITS-1:0]  stride_setting = ROW_STRIDE_RESET;
   logic [LIMIT_BITS-1:0]       left_setting   = LEFT_LIMIT_RESET;
   logic [LIMIT_BITS-1:0]       right_setting  = RIGHT_LIMIT_RESET;
   logic [FRAME_WIDTH_BITS-1:0] column_pos     = '0;
   logic [ROW_STRIDE_BITS-1:0]  row_pos        = '0;
   logic [COUNT_BITS-1:0]       left_tally     = '0;
   logic [COUNT_BITS-1:0]       middle_tally   = '0;
   logic [COUNT_BITS-1:0]       right_tally    = '0;

   pixel_word_type pixel_queue[$];
   pixel_word_type offered;
   steer_word_type pending_steer[$];
   steer_word_type received;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;
   int hold_served        = 0;
   int hold_left          = 0;
   int mismatch_count     = 0;
   int idle_cycles        = 0;

   white_blob_region_steering_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] value);
      return (value == COUNT_MAX) ? value : value + 1'b1;
   endfunction

   function automatic void count_and_steer(input pixel_word_type pixel);
      logic [FRAME_WIDTH_BITS:0] column_next;
      logic [ROW_STRIDE_BITS-1:0] row_next;
      logic [COUNT_BITS-1:0] peak;
      steer_word_type outcome;
      if (pixel.red == WHITE_LEVEL && pixel.green == WHITE_LEVEL &&
          pixel.blue == WHITE_LEVEL && row_pos == '0) begin
         if (column_pos <= left_setting) begin
            left_tally = bump(left_tally);
         end else if (column_pos >= right_setting) begin
            right_tally = bump(right_tally);
         end else begin
            middle_tally = bump(middle_tally);
         end
      end
      column_next = {1'b0, column_pos} + 1'b1;
      if (column_next >= {1'b0, width_setting} ||
          column_next[FRAME_WIDTH_BITS-1:0] == '0) begin
         column_pos = '0;
         row_next   = row_pos + 1'b1;
         row_pos    = (row_next >= stride_setting) ? '0 : row_next;
      end else begin
         column_pos = column_next[FRAME_WIDTH_BITS-1:0];
      end
      if (pixel.frame_end) begin
         peak = left_tally;
         if (middle_tally > peak) peak = middle_tally;
         if (right_tally > peak) peak = right_tally;
         if (peak == '0) begin
            outcome.decision = DEC_STOP;
         end else if (peak == left_tally) begin
            outcome.decision = DEC_LEFT;
         end else if (peak == right_tally) begin
            outcome.decision = DEC_RIGHT;
         end else begin
            outcome.decision = DEC_FORWARD;
         end
         outcome.left_count   = left_tally;
         outcome.middle_count = middle_tally;
         outcome.right_count  = right_tally;
         pending_steer.push_back(outcome);
         left_tally   = '0;
         middle_tally = '0;
         right_tally  = '0;
         column_pos   = '0;
         row_pos      = '0;
      end
   endfunction

   function automatic void check_field(input string label,
                                       input logic [COUNT_BITS-1:0] wanted,
                                       input logic [COUNT_BITS-1:0] seen);
      if (wanted !== seen) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, wanted, seen);
         mismatch_count++;
      end
   endfunction

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) count_and_steer(offered);
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered = pixel_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {offered.blue, offered.green, offered.red};
               req_tlast  <= offered.frame_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_steer.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               received = pending_steer.pop_front();
               check_field("decision", COUNT_BITS'(received.decision), COUNT_BITS'(rsp_tdata[1:0]));
               check_field("left_count", received.left_count, rsp_tdata[21:2]);
               check_field("middle_count", received.middle_count, rsp_tdata[41:22]);
               check_field("right_count", received.right_count, rsp_tdata[61:42]);
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic frame_end);
      pixel_word_type word;
      word = '{red, green, blue, frame_end};
      while (pixel_queue.size() >= QUEUE_ROOM) @(posedge clock);
      pixel_queue.push_back(word);
   endtask

   task automatic push_white(input logic frame_end);
      push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, frame_end);
   endtask

   task automatic push_random_pixel(input logic frame_end);
      logic [7:0] lane[3];
      int pick;
      pick = $urandom_range(99);
      foreach (lane[i]) lane[i] = (pick < 60) ? WHITE_LEVEL : 8'($urandom);
      if (pick >= 45 && pick < 60) lane[$urandom_range(2)] = 8'($urandom_range(254));
      push_pixel(lane[0], lane[1], lane[2], frame_end);
   endtask

   task automatic settle_block();
      while (pixel_queue.size() != 0 || req_tvalid || pending_steer.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FRAME_WIDTH: width_setting  = value;
         CSR_ROW_STRIDE:  stride_setting = value[ROW_STRIDE_BITS-1:0];
         CSR_LEFT_LIMIT:  left_setting   = value;
         CSR_RIGHT_LIMIT: right_setting  = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_region(input logic [11:0] width, input logic [3:0] stride,
                             input logic [11:0] left_lim, input logic [11:0] right_lim);
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_ROW_STRIDE, {8'd0, stride});
      write_register(CSR_LEFT_LIMIT, left_lim);
      write_register(CSR_RIGHT_LIMIT, right_lim);
   endtask

   task automatic choose_settings();
      logic [11:0] width;
      logic [11:0] limit[2];
      logic [3:0] stride;
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0:       width = 12'd4095;
         1:       width = 12'd0;
         2:       width = 12'd1;
         default: width = 12'($urandom_range(2, 12));
      endcase
      stride = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      foreach (limit[i]) begin
         case ($urandom_range(4))
            0:       limit[i] = 12'd0;
            1:       limit[i] = 12'd4095;
            default: limit[i] = 12'($urandom_range(width));
         endcase
      end
      set_region(width, stride, limit[0], limit[1]);
      if ($urandom_range(3) == 0) write_register(CSR_UNUSED_INDEX, 12'($urandom));
   endtask

   task automatic run_frames(input int sender_pct, input int receiver_pct,
                             input int item_goal);
      int sent;
      int span;
      logic close;
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      choose_settings();
      sent = 0;
      while (sent < item_goal) begin
         span  = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
         close = (sent + span < item_goal) || ($urandom_range(1) == 1);
         for (int k = 0; k < span; k++) push_random_pixel(close && k == span - 1);
         sent += span;
      end
      settle_block();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, near-white pixels
      push_white(1'b1);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      push_pixel(8'd255, 8'd255, 8'd254, 1'b1);
      push_pixel(8'd255, 8'd254, 8'd255, 1'b0);
      push_pixel(8'd254, 8'd255, 8'd255, 1'b1);
      settle_block();

      // three regions, skipped row, ties to right and forward
      set_region(12'd4, 4'd2, 12'd0, 12'd2);
      repeat (8) push_white(1'b0);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      push_white(1'b1);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      push_white(1'b1);
      settle_block();

      // crossed limits
      set_region(12'd4, 4'd2, 12'd2, 12'd1);
      repeat (3) push_white(1'b0);
      push_white(1'b1);
      settle_block();

      // left and right tie
      set_region(12'd4, 4'd2, 12'd0, 12'd3);
      push_white(1'b0);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      push_white(1'b1);
      settle_block();

      // zero width and zero stride
      set_region(12'd0, 4'd0, 12'd0, 12'd3);
      push_white(1'b0);
      push_white(1'b0);
      push_white(1'b1);
      settle_block();

      // lower the width in mid-row
      write_register(CSR_FRAME_WIDTH, 12'd8);
      repeat (5) push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      settle_block();
      write_register(CSR_FRAME_WIDTH, 12'd3);
      write_register(CSR_UNUSED_INDEX, 12'hFFF);
      push_white(1'b0);
      push_white(1'b0);
      push_white(1'b1);
      settle_block();

      for (int round = 0; round < 2; round++) begin
         run_frames(0, 0, 100);
         run_frames(55, 0, 100);
         run_frames(0, 55, 100);
         run_frames(7, 7, 100);
      end

      // hold the receiver and back up the input with short frames
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      set_region(12'd3, 4'd1, 12'd0, 12'd2);
      hold_requests++;
      for (int f = 0; f < 60; f++) begin
         if ($urandom_range(1) == 1) push_random_pixel(1'b0);
         push_random_pixel(1'b1);
      end
      settle_block();

      if (mismatch_count == 0 && pending_steer.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
